// ===== src/uart_dual_ring_buffer_core_defines.svh =====
// assertion macros shared by the uart dual ring buffer rtl
// no dependencies; expects clock and reset in the using module
`ifndef UART_DUAL_RING_BUFFER_CORE_DEFINES_SVH
`define UART_DUAL_RING_BUFFER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UDRB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define UDRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/udrb_pkg.sv =====
// shared types and constants for the uart dual ring buffer
// used by the controller, datapath and top level
package udrb_pkg;

   // default ring depths
   localparam int RX_DEPTH_DEF = 32;
   localparam int TX_DEPTH_DEF = 256;

   // operation codes of an input item
   typedef enum logic [2:0] {
      OP_GET      = 3'd0,
      OP_PUT      = 3'd1,
      OP_LINE_RX  = 3'd2,
      OP_TX_READY = 3'd3,
      OP_RX_OFF   = 3'd4,
      OP_RX_ON    = 3'd5
   } op_type;

   // controller states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

endpackage

// ===== src/uart_dual_ring_buffer_core.sv =====
// timing: the item is captured on the accepting edge, the controller runs its execute state,
// and the result strobe is registered from that execute state; busy covers the execute state
// that follows the registered ram read of both ring heads, so no new item is taken while busy
// reset: synchronous, active high; ring indices cleared, receiver and rx irq on,
// tx irq off; ram contents are not cleared, there is no clearing pass
// results go out as a one-cycle strobe, the receiver cannot stall them
module uart_dual_ring_buffer_core #(
   parameter int RX_DEPTH = udrb_pkg::RX_DEPTH_DEF,
   parameter int TX_DEPTH = udrb_pkg::TX_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_operation,
   input  logic [7:0] req_data_byte,
   output logic       rsp_strobe,
   output logic       rsp_get_valid,
   output logic [7:0] rsp_get_byte,
   output logic       rsp_put_rejected,
   output logic       rsp_line_tx_valid,
   output logic [7:0] rsp_line_tx_byte,
   output logic       rsp_rx_dropped,
   output logic       rsp_rx_event,
   output logic       rsp_tx_irq_on,
   output logic       rsp_receiver_enabled_out
);
   import udrb_pkg::*;

   ctrl_cmd_type cmd;

   // controller
   udrb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // datapath
   udrb_datapath #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .req_operation            (req_operation),
      .req_data_byte            (req_data_byte),
      .rsp_strobe               (rsp_strobe),
      .rsp_get_valid            (rsp_get_valid),
      .rsp_get_byte             (rsp_get_byte),
      .rsp_put_rejected         (rsp_put_rejected),
      .rsp_line_tx_valid        (rsp_line_tx_valid),
      .rsp_line_tx_byte         (rsp_line_tx_byte),
      .rsp_rx_dropped           (rsp_rx_dropped),
      .rsp_rx_event             (rsp_rx_event),
      .rsp_tx_irq_on            (rsp_tx_irq_on),
      .rsp_receiver_enabled_out (rsp_receiver_enabled_out)
   );

endmodule

// ===== src/udrb_ram.sv =====
// generic single-write, single-read ram with registered read data
// no package dependencies
module udrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/udrb_ctrl.sv =====
// controller state machine: accepts an item, then runs its execute state
// depends on udrb_pkg
module udrb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output udrb_pkg::ctrl_cmd_type cmd
);
   import udrb_pkg::*;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy        = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/udrb_datapath.sv =====
// datapath: ring indices, interrupt enables, the two byte rams and result registers
// depends on udrb_pkg, udrb_ram and the assertion macro header
`include "uart_dual_ring_buffer_core_defines.svh"

module udrb_datapath #(
   parameter int RX_DEPTH = udrb_pkg::RX_DEPTH_DEF,
   parameter int TX_DEPTH = udrb_pkg::TX_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  udrb_pkg::ctrl_cmd_type cmd,
   input  logic [2:0]             req_operation,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_strobe,
   output logic                   rsp_get_valid,
   output logic [7:0]             rsp_get_byte,
   output logic                   rsp_put_rejected,
   output logic                   rsp_line_tx_valid,
   output logic [7:0]             rsp_line_tx_byte,
   output logic                   rsp_rx_dropped,
   output logic                   rsp_rx_event,
   output logic                   rsp_tx_irq_on,
   output logic                   rsp_receiver_enabled_out
);
   import udrb_pkg::*;

   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
   localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

   // captured item
   op_type     op_ff;
   logic [7:0] byte_ff;

   // ring indices and enables
   logic [RX_AW-1:0] rx_rd_ff, rx_rd_in, rx_wr_ff, rx_wr_in;
   logic [TX_AW-1:0] tx_rd_ff, tx_rd_in, tx_wr_ff, tx_wr_in;
   logic             recv_en_ff, recv_en_in;
   logic             rx_irq_ff, rx_irq_in;
   logic             tx_irq_ff, tx_irq_in;

   // result registers
   logic       strobe_ff;
   logic       get_valid_ff, get_valid_in;
   logic [7:0] get_byte_ff, get_byte_in;
   logic       put_rej_ff, put_rej_in;
   logic       tx_valid_ff, tx_valid_in;
   logic [7:0] tx_byte_ff, tx_byte_in;
   logic       dropped_ff, dropped_in;
   logic       event_ff, event_in;
   logic       tx_irq_out_ff, recv_en_out_ff;

   // ram signals
   logic             rx_wr_en, tx_wr_en;
   logic [7:0]       rx_rdata, tx_rdata;
   logic [RX_AW-1:0] rx_rd_next, rx_wr_next;
   logic [TX_AW-1:0] tx_rd_next, tx_wr_next;
   logic             rx_empty, rx_full, tx_empty, tx_full;

   // ring position arithmetic
   assign rx_rd_next = (rx_rd_ff == RX_LAST) ? '0 : rx_rd_ff + RX_AW'(1);
   assign rx_wr_next = (rx_wr_ff == RX_LAST) ? '0 : rx_wr_ff + RX_AW'(1);
   assign tx_rd_next = (tx_rd_ff == TX_LAST) ? '0 : tx_rd_ff + TX_AW'(1);
   assign tx_wr_next = (tx_wr_ff == TX_LAST) ? '0 : tx_wr_ff + TX_AW'(1);
   assign rx_empty   = (rx_rd_ff == rx_wr_ff);
   assign rx_full    = (rx_wr_next == rx_rd_ff);
   assign tx_empty   = (tx_rd_ff == tx_wr_ff);
   assign tx_full    = (tx_wr_next == tx_rd_ff);

   // byte stores, read at the head index when the item is captured
   udrb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_ff),
      .wr_data (byte_ff),
      .rd_addr (rx_rd_ff),
      .rd_data (rx_rdata)
   );

   udrb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_ff),
      .wr_data (byte_ff),
      .rd_addr (tx_rd_ff),
      .rd_data (tx_rdata)
   );

   // item execution
   always_comb begin
      rx_rd_in     = rx_rd_ff;
      rx_wr_in     = rx_wr_ff;
      tx_rd_in     = tx_rd_ff;
      tx_wr_in     = tx_wr_ff;
      recv_en_in   = recv_en_ff;
      rx_irq_in    = rx_irq_ff;
      tx_irq_in    = tx_irq_ff;
      get_valid_in = 1'b0;
      get_byte_in  = 8'd0;
      put_rej_in   = 1'b0;
      tx_valid_in  = 1'b0;
      tx_byte_in   = 8'd0;
      dropped_in   = 1'b0;
      event_in     = 1'b0;
      rx_wr_en     = 1'b0;
      tx_wr_en     = 1'b0;
      if (cmd.execute) begin
         case (op_ff)
            OP_GET: begin
               if (!rx_empty) begin
                  get_valid_in = 1'b1;
                  get_byte_in  = rx_rdata;
                  rx_rd_in     = rx_rd_next;
               end
            end
            OP_PUT: begin
               // receiver turns on first
               if (!recv_en_ff) begin
                  recv_en_in = 1'b1;
                  rx_irq_in  = 1'b1;
                  if (!tx_empty) begin
                     tx_irq_in = 1'b1;
                  end
               end
               if (tx_full) begin
                  put_rej_in = 1'b1;
               end else begin
                  tx_wr_en  = 1'b1;
                  tx_wr_in  = tx_wr_next;
                  tx_irq_in = 1'b1;
               end
            end
            OP_LINE_RX: begin
               if (recv_en_ff) begin
                  event_in = 1'b1;
                  if (rx_full) begin
                     dropped_in = 1'b1;
                  end else begin
                     rx_wr_en = 1'b1;
                     rx_wr_in = rx_wr_next;
                  end
               end
            end
            OP_TX_READY: begin
               if (tx_irq_ff) begin
                  if (!tx_empty) begin
                     tx_valid_in = 1'b1;
                     tx_byte_in  = tx_rdata;
                     tx_rd_in    = tx_rd_next;
                  end else begin
                     tx_irq_in = 1'b0;
                  end
               end
            end
            OP_RX_OFF: begin
               if (recv_en_ff) begin
                  recv_en_in = 1'b0;
                  rx_irq_in  = 1'b0;
                  tx_irq_in  = 1'b0;
               end
            end
            OP_RX_ON: begin
               if (!recv_en_ff) begin
                  recv_en_in = 1'b1;
                  rx_irq_in  = 1'b1;
                  if (!tx_empty) begin
                     tx_irq_in = 1'b1;
                  end
               end
            end
            default: begin
               recv_en_in = recv_en_ff;
            end
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_operation);
         byte_ff <= req_data_byte;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_rd_ff   <= '0;
         rx_wr_ff   <= '0;
         tx_rd_ff   <= '0;
         tx_wr_ff   <= '0;
         recv_en_ff <= 1'b1;
         rx_irq_ff  <= 1'b1;
         tx_irq_ff  <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         rx_rd_ff   <= rx_rd_in;
         rx_wr_ff   <= rx_wr_in;
         tx_rd_ff   <= tx_rd_in;
         tx_wr_ff   <= tx_wr_in;
         recv_en_ff <= recv_en_in;
         rx_irq_ff  <= rx_irq_in;
         tx_irq_ff  <= tx_irq_in;
         strobe_ff  <= cmd.execute;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         get_valid_ff   <= get_valid_in;
         get_byte_ff    <= get_byte_in;
         put_rej_ff     <= put_rej_in;
         tx_valid_ff    <= tx_valid_in;
         tx_byte_ff     <= tx_byte_in;
         dropped_ff     <= dropped_in;
         event_ff       <= event_in;
         tx_irq_out_ff  <= tx_irq_in;
         recv_en_out_ff <= recv_en_in;
      end
   end

   assign rsp_strobe               = strobe_ff;
   assign rsp_get_valid            = get_valid_ff;
   assign rsp_get_byte             = get_byte_ff;
   assign rsp_put_rejected         = put_rej_ff;
   assign rsp_line_tx_valid        = tx_valid_ff;
   assign rsp_line_tx_byte         = tx_byte_ff;
   assign rsp_rx_dropped           = dropped_ff;
   assign rsp_rx_event             = event_ff;
   assign rsp_tx_irq_on            = tx_irq_out_ff;
   assign rsp_receiver_enabled_out = recv_en_out_ff;

   // checks
   `UDRB_ASSERT_NEXT(a_strobe_after_exec, cmd.execute, strobe_ff, "result strobe missing")
   `UDRB_ASSERT_NEXT(a_no_stray_strobe, !cmd.execute, !strobe_ff, "result strobe without item")
   `UDRB_ASSERT_SAME(a_rx_off_tx_irq_off, !recv_en_ff, !tx_irq_ff, "tx irq on with receiver off")
   `UDRB_ASSERT_SAME(a_rx_irq_tracks_en, 1'b1, rx_irq_ff == recv_en_ff, "rx irq enable mismatch")
   `UDRB_ASSERT_SAME(a_tx_send_irq_on, strobe_ff && tx_valid_ff, tx_irq_out_ff,
                     "byte sent with tx irq off")

endmodule
